// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PPV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppv assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PPV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppv assertion failed");

`endif

// ----- rtl/core/ppv_pkg.sv -----
// Shared types, constants and float decode for the pose packet validator.
package ppv_pkg;

	localparam int VALUES_PER_BONE  = 7;
	localparam int HEADER_WORDS     = 5;
	localparam int BONES_DEF        = 14;
	localparam int MAX_PKT_BYTES_DEF = 2048;

	localparam logic [31:0] MAGIC_ONE = 32'h314D4547;
	localparam logic [31:0] MAGIC_TWO = 32'h324D4547;

	localparam logic [1:0] PROTO_NONE = 2'd0;
	localparam logic [1:0] PROTO_ONE  = 2'd1;
	localparam logic [1:0] PROTO_TWO  = 2'd2;

	localparam logic [3:0] STAT_PROTO1    = 4'd0;
	localparam logic [3:0] STAT_PROTO2    = 4'd1;
	localparam logic [3:0] STAT_LEN       = 4'd2;
	localparam logic [3:0] STAT_MAGIC     = 4'd3;
	localparam logic [3:0] STAT_COUNT     = 4'd4;
	localparam logic [3:0] STAT_NONFINITE = 4'd5;
	localparam logic [3:0] STAT_RANGE     = 4'd6;
	localparam logic [3:0] STAT_NORM      = 4'd7;
	localparam logic [3:0] STAT_MISMATCH  = 4'd8;
	localparam logic [3:0] STAT_DUP       = 4'd9;
	localparam logic [3:0] STAT_OLD       = 4'd10;

	// 20.0 as single, 1e-12 as double
	localparam logic [30:0] POS_LIMIT = 31'h41A00000;
	localparam logic [62:0] NORM_MIN  = 63'h3D719799812DEA11;

	typedef logic [VALUES_PER_BONE-1:0][31:0] bone_vals_t;

	typedef struct packed {
		logic            done;
		logic [3:0]      err;
		logic [3:0][31:0] quat;
	} norm_res_t;

	// value = m * 2^e, m normalized to bit 23
	typedef struct packed {
		logic               z;
		logic               s;
		logic [23:0]        m;
		logic signed [11:0] e;
	} fdec_t;

	function automatic fdec_t fdec(input logic [31:0] b);
		fdec_t        d;
		logic [23:0]  raw;
		logic [4:0]   lz;
		logic [11:0]  eb;
		raw = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		eb  = (b[30:23] == 8'd0) ? 12'd1 : {4'd0, b[30:23]};
		lz  = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (raw[i]) lz = 5'(23 - i);
		end
		d.z = (raw == 24'd0);
		d.s = b[31];
		d.m = raw << lz;
		d.e = $signed(eb) - 12'sd150 - $signed({7'd0, lz});
		return d;
	endfunction

endpackage

// ----- rtl/core/ppv_norm.sv -----
// Shared iterative unit: value checks, square sum, square root and quaternion divide.
module ppv_norm import ppv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  bone_vals_t vals,
	output norm_res_t  res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQ   = 4'd1;
	localparam logic [3:0] S_ADD  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_SQRT = 4'd4;
	localparam logic [3:0] S_RND  = 4'd5;
	localparam logic [3:0] S_DSET = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]         state_q;
	logic [1:0]         idx_q;
	logic [5:0]         cnt_q;
	logic               done_q;
	logic [3:0]         err_q;
	logic [3:0][31:0]   quat_q;
	logic [52:0]        acc_m_q;
	logic signed [11:0] acc_e_q;
	logic               acc_z_q;
	logic [52:0]        prod_m_q;
	logic signed [11:0] prod_e_q;
	logic               prod_z_q;
	logic [109:0]       xs_q;
	logic [58:0]        rem_q;
	logic [54:0]        root_q;
	logic [52:0]        r_m_q;
	logic signed [11:0] r_e_q;
	logic [54:0]        dv_rem_q;
	logic [55:0]        quo_q;
	logic signed [11:0] qe_q;
	logic               qs_q;

	fdec_t              qd;
	logic [47:0]        sq;
	logic               bad_fin, bad_rng;

	logic [52:0]        big_m, sml_m, add_m;
	logic signed [11:0] big_e, sml_e, dif, add_e;
	logic [55:0]        sml_x, sml_sh;
	logic               sml_st, add_up;
	logic [56:0]        sum;
	logic [55:0]        sum_n;
	logic [53:0]        add_r;

	logic               chk_ok, odd, fin;
	logic signed [11:0] e_even;

	logic [58:0]        sq_r2, sq_trial;
	logic               sq_ge, rt_up;
	logic [53:0]        rt_r;

	logic               dv_ge;
	logic [54:0]        dv_sub;

	logic [52:0]        dm, dd;
	logic               dg, drs, dup, normal, fg, fst, kup;
	logic [53:0]        d1, dx, kx;
	logic signed [11:0] ed_base, ed0, ed, shn;
	logic [5:0]         sh;
	logic [24:0]        kf;
	logic [7:0]         bexp;
	logic [31:0]        fbits;

	always_comb begin
		qd = fdec(vals[3'd3 + {1'b0, idx_q}]);
		sq = qd.m * qd.m;
		bad_fin = 1'b0;
		bad_rng = 1'b0;
		for (int i = 0; i < VALUES_PER_BONE; i++) begin
			if (vals[i][30:23] == 8'hFF) bad_fin = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			if (vals[i][30:0] > POS_LIMIT) bad_rng = 1'b1;
		end
	end

	// positive double add, round to nearest even
	always_comb begin
		if (acc_e_q >= prod_e_q) begin
			big_m = acc_m_q;  big_e = acc_e_q;  sml_m = prod_m_q; sml_e = prod_e_q;
		end else begin
			big_m = prod_m_q; big_e = prod_e_q; sml_m = acc_m_q;  sml_e = acc_e_q;
		end
		dif   = big_e - sml_e;
		sml_x = {sml_m, 3'b000};
		if (dif > 12'sd55) begin
			sml_sh = 56'd0;
			sml_st = 1'b1;
		end else begin
			sml_sh = sml_x >> dif[5:0];
			sml_st = |(sml_x & ((56'd1 << dif[5:0]) - 56'd1));
		end
		sum = {1'b0, big_m, 3'b000} + {1'b0, sml_sh[55:1], sml_sh[0] | sml_st};
		if (sum[56]) begin
			sum_n = {sum[56:2], sum[1] | sum[0]};
			add_e = big_e + 12'sd1;
		end else begin
			sum_n = sum[55:0];
			add_e = big_e;
		end
		add_up = sum_n[2] && ((|sum_n[1:0]) || sum_n[3]);
		add_r  = {1'b0, sum_n[55:3]} + {53'd0, add_up};
		if (add_r[53]) begin
			add_m = add_r[53:1];
			add_e = add_e + 12'sd1;
		end else begin
			add_m = add_r[52:0];
		end
	end

	always_comb begin
		chk_ok = !acc_z_q && ({11'(acc_e_q + 12'sd1075), acc_m_q[51:0]} >= NORM_MIN);
		odd    = acc_e_q[0];
		e_even = acc_e_q - {11'd0, odd};
		sq_r2    = {rem_q[56:0], xs_q[109:108]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge    = (sq_r2 >= sq_trial);
		rt_up    = root_q[1] && (root_q[0] || (rem_q != 59'd0) || root_q[2]);
		rt_r     = {1'b0, root_q[54:2]} + {53'd0, rt_up};
		dv_ge    = (dv_rem_q >= {2'b00, r_m_q});
		dv_sub   = dv_ge ? (dv_rem_q - {2'b00, r_m_q}) : dv_rem_q;
		fin      = ((state_q == S_IDLE) && start && (bad_fin || bad_rng)) ||
			((state_q == S_CHK) && !chk_ok) ||
			((state_q == S_DSET) && qd.z && (idx_q == 2'd3)) ||
			((state_q == S_FIN) && (idx_q == 2'd3));
	end

	// quotient to double, then double to single
	always_comb begin
		ed_base = qe_q - r_e_q - 12'sd81;
		if (quo_q[55]) begin
			dm  = quo_q[55:3];
			dg  = quo_q[2];
			drs = (|quo_q[1:0]) || (dv_rem_q != 55'd0);
			ed0 = ed_base;
		end else begin
			dm  = quo_q[54:2];
			dg  = quo_q[1];
			drs = quo_q[0] || (dv_rem_q != 55'd0);
			ed0 = ed_base - 12'sd1;
		end
		dup = dg && (drs || dm[0]);
		d1  = {1'b0, dm} + {53'd0, dup};
		if (d1[53]) begin
			dd = d1[53:1];
			ed = ed0 + 12'sd1;
		end else begin
			dd = d1[52:0];
			ed = ed0;
		end
		normal = (ed >= -12'sd178);
		shn    = -12'sd149 - ed;
		if (normal)
			sh = 6'd29;
		else if (shn > 12'sd63)
			sh = 6'd63;
		else
			sh = shn[5:0];
		dx   = {dd, 1'b0};
		kx   = dx >> sh;
		fg   = kx[0];
		fst  = |(dx & ((54'd1 << sh) - 54'd1));
		kup  = fg && (fst || kx[1]);
		kf   = {1'b0, kx[24:1]} + {24'd0, kup};
		bexp = normal ? 8'(ed + 12'sd178) : 8'd0;
		fbits = {qs_q, {bexp, 23'd0} + {6'd0, kf}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						quat_q  <= '0;
						idx_q   <= 2'd0;
						acc_z_q <= 1'b1;
						if (bad_fin || bad_rng) begin
							err_q   <= bad_fin ? STAT_NONFINITE : STAT_RANGE;
						end else begin
							err_q   <= 4'd0;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					prod_z_q <= qd.z;
					if (sq[47]) begin
						prod_m_q <= {sq, 5'd0};
						prod_e_q <= qd.e + qd.e - 12'sd5;
					end else begin
						prod_m_q <= {sq[46:0], 6'd0};
						prod_e_q <= qd.e + qd.e - 12'sd6;
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (!prod_z_q) begin
						acc_z_q <= 1'b0;
						if (acc_z_q) begin
							acc_m_q <= prod_m_q;
							acc_e_q <= prod_e_q;
						end else begin
							acc_m_q <= add_m;
							acc_e_q <= add_e;
						end
					end
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd3) ? S_CHK : S_SQ;
				end
				S_CHK: begin
					if (!chk_ok) begin
						err_q   <= STAT_NORM;
						state_q <= S_IDLE;
					end else begin
						xs_q    <= odd ? {acc_m_q, 57'd0} : {1'b0, acc_m_q, 56'd0};
						r_e_q   <= ((e_even - 12'sd56) >>> 1) + 12'sd2;
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= 6'd54;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					rem_q   <= sq_ge ? (sq_r2 - sq_trial) : sq_r2;
					root_q  <= {root_q[53:0], sq_ge};
					xs_q    <= {xs_q[107:0], 2'b00};
					cnt_q   <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) state_q <= S_RND;
				end
				S_RND: begin
					if (rt_r[53]) begin
						r_m_q <= rt_r[53:1];
						r_e_q <= r_e_q + 12'sd1;
					end else begin
						r_m_q <= rt_r[52:0];
					end
					idx_q   <= 2'd0;
					state_q <= S_DSET;
				end
				S_DSET: begin
					if (qd.z) begin
						quat_q[idx_q] <= {qd.s, 31'd0};
						idx_q         <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end else begin
						dv_rem_q <= {2'b00, qd.m, 29'd0};
						qe_q     <= qd.e;
						qs_q     <= qd.s;
						cnt_q    <= 6'd55;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q    <= {quo_q[54:0], dv_ge};
					dv_rem_q <= {dv_sub[53:0], 1'b0};
					cnt_q    <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) state_q <= S_FIN;
				end
				S_FIN: begin
					quat_q[idx_q] <= fbits;
					idx_q         <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DSET;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.err  = err_q;
	assign res.quat = quat_q;

endmodule

// ----- rtl/core/pose_packet_validator.sv -----
// Top level: packet framing, header and sequence checks, result register.
//  channel | dir | handshake               | payload
//  in      | in  | in_valid / in_ready     | packet_word, last_word, final_bytes
//  out     | out | out_valid / out_ready   | kind .. dropped_gap
//  cfg     | in  | cfg_wr_en               | cfg_wr_data (expected protocol)
// The word that closes a bone runs the shared normalizer: 55 root steps,
// then per nonzero quaternion part a setup, 56 divide steps and a pack.
// A verdict is written once the result register is free. in_ready is low
// while a bone or verdict is in progress; a waiting result stalls only the
// next bone or verdict.
// Reset clears all control and sequence state; no clearing pass.
module pose_packet_validator import ppv_pkg::*; #(
	parameter int BONES            = BONES_DEF,
	parameter int MAX_PACKET_BYTES = MAX_PKT_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] packet_word,
	input  logic        last_word,
	input  logic [2:0]  final_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  bone_index,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z,
	output logic [31:0] quat_w,
	output logic [31:0] quat_x,
	output logic [31:0] quat_y,
	output logic [31:0] quat_z,
	output logic [3:0]  status,
	output logic [31:0] sequence_res,
	output logic [30:0] dropped_gap
);

	localparam int PACKET_BYTES = HEADER_WORDS * 4 + BONES * VALUES_PER_BONE * 4;
	localparam int BW  = $clog2(MAX_PACKET_BYTES + PACKET_BYTES + 8);
	localparam int BIW = (BONES > 1) ? $clog2(BONES) : 1;
	localparam logic [BW-1:0] PKT_B = BW'(PACKET_BYTES);
	localparam logic [BW-1:0] MAX_B = BW'(MAX_PACKET_BYTES);
	localparam logic [BW-3:0] W_MAGIC = (BW-2)'(0);
	localparam logic [BW-3:0] W_VER   = (BW-2)'(1);
	localparam logic [BW-3:0] W_SEQ   = (BW-2)'(2);
	localparam logic [BW-3:0] W_BODY  = (BW-2)'(HEADER_WORDS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_VERD = 2'd2;

	logic [1:0]     st_q;
	logic [1:0]     exp_proto_q;
	logic [BW-1:0]  byte_count_q;
	logic [3:0]     first_err_q;
	logic [1:0]     pkt_proto_q;
	logic [31:0]    pkt_seq_q;
	logic           seq_valid_q;
	logic [31:0]    last_seq_q;
	logic [1:0]     last_proto_q;
	logic [2:0]     slot_q;
	logic [BIW-1:0] bone_q;
	logic           last_pend_q;
	logic           norm_start_q;
	logic           ndone_q;
	bone_vals_t     bone_vals_q;

	logic           out_valid_q, kind_q;
	logic [3:0]     bone_index_q, status_q;
	logic [31:0]    pos_x_q, pos_y_q, pos_z_q, quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic [31:0]    seq_res_q;
	logic [30:0]    gap_q;

	norm_res_t      nres;
	logic           acc;
	logic [2:0]     nb;
	logic [BW-1:0]  bc_sum;
	logic           take;
	logic           close;
	logic [BW-3:0]  w;
	logic [3:0]     fe_bone;
	logic           pchg, sv;
	logic [31:0]    delta;

	ppv_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start_q),
		.vals   (bone_vals_q),
		.res    (nres)
	);

	always_comb begin
		in_ready = (st_q == ST_IDLE);
		acc      = in_valid && in_ready;
		nb       = (last_word && final_bytes != 3'd0 && final_bytes <= 3'd4) ? final_bytes : 3'd4;
		bc_sum   = byte_count_q + BW'(nb);
		take     = (nb == 3'd4) && (byte_count_q + BW'(4) <= PKT_B);
		w        = byte_count_q[BW-1:2];
		close    = take && (w >= W_BODY) && (slot_q == 3'(VALUES_PER_BONE - 1));
		fe_bone  = (first_err_q == 4'd0) ? nres.err : first_err_q;
		pchg     = (pkt_proto_q != last_proto_q);
		sv       = seq_valid_q && !pchg;
		delta    = pkt_seq_q - last_seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			exp_proto_q  <= PROTO_NONE;
			byte_count_q <= '0;
			first_err_q  <= 4'd0;
			pkt_proto_q  <= PROTO_NONE;
			pkt_seq_q    <= '0;
			seq_valid_q  <= 1'b0;
			last_seq_q   <= '0;
			last_proto_q <= PROTO_NONE;
			slot_q       <= '0;
			bone_q       <= '0;
			last_pend_q  <= 1'b0;
			norm_start_q <= 1'b0;
			ndone_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			norm_start_q <= acc && close;
			if (cfg_wr_en) exp_proto_q <= cfg_wr_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						byte_count_q <= (bc_sum > MAX_B) ? MAX_B : bc_sum;
						last_pend_q  <= last_word;
						st_q         <= close ? ST_NORM : (last_word ? ST_VERD : ST_IDLE);
						if (take) begin
							if (w == W_MAGIC) begin
								pkt_proto_q <= (packet_word == MAGIC_ONE) ? PROTO_ONE :
									((packet_word == MAGIC_TWO) ? PROTO_TWO : PROTO_NONE);
							end else if (w == W_VER) begin
								if (pkt_proto_q == PROTO_NONE ||
								    packet_word[15:0] != {14'd0, pkt_proto_q}) begin
									pkt_proto_q <= PROTO_NONE;
									if (first_err_q == 4'd0) first_err_q <= STAT_MAGIC;
								end else if (packet_word[31:16] != 16'(BONES)) begin
									if (first_err_q == 4'd0) first_err_q <= STAT_COUNT;
								end
							end else if (w == W_SEQ) begin
								pkt_seq_q <= packet_word;
							end else if (w >= W_BODY) begin
								bone_vals_q[slot_q] <= packet_word;
								slot_q <= close ? 3'd0 : slot_q + 3'd1;
							end
						end
					end
				end
				ST_NORM: begin
					if ((nres.done || ndone_q) && !out_valid_q) begin
						ndone_q      <= 1'b0;
						first_err_q  <= fe_bone;
						out_valid_q  <= 1'b1;
						kind_q       <= 1'b0;
						bone_index_q <= 4'(bone_q);
						pos_x_q      <= bone_vals_q[0];
						pos_y_q      <= bone_vals_q[1];
						pos_z_q      <= bone_vals_q[2];
						quat_w_q     <= nres.quat[0];
						quat_x_q     <= nres.quat[1];
						quat_y_q     <= nres.quat[2];
						quat_z_q     <= nres.quat[3];
						status_q     <= (fe_bone != 4'd0) ? fe_bone :
							((pkt_proto_q == PROTO_TWO) ? STAT_PROTO2 : STAT_PROTO1);
						seq_res_q    <= pkt_seq_q;
						gap_q        <= '0;
						bone_q       <= bone_q + BIW'(1);
						st_q         <= last_pend_q ? ST_VERD : ST_IDLE;
					end else if (nres.done) begin
						ndone_q <= 1'b1;
					end
				end
				ST_VERD: begin
					if (!out_valid_q) begin
						out_valid_q  <= 1'b1;
						kind_q       <= 1'b1;
						bone_index_q <= '0;
						pos_x_q      <= '0;
						pos_y_q      <= '0;
						pos_z_q      <= '0;
						quat_w_q     <= '0;
						quat_x_q     <= '0;
						quat_y_q     <= '0;
						quat_z_q     <= '0;
						seq_res_q    <= pkt_seq_q;
						if (byte_count_q != PKT_B) begin
							status_q <= STAT_LEN;
							gap_q    <= '0;
						end else if (first_err_q != 4'd0) begin
							status_q <= first_err_q;
							gap_q    <= '0;
						end else if (exp_proto_q != PROTO_NONE && pkt_proto_q != exp_proto_q) begin
							status_q <= STAT_MISMATCH;
							gap_q    <= '0;
						end else begin
							last_proto_q <= pkt_proto_q;
							seq_valid_q  <= 1'b1;
							if (sv && delta == 32'd0) begin
								status_q <= STAT_DUP;
								gap_q    <= '0;
							end else if (sv && delta[31]) begin
								status_q <= STAT_OLD;
								gap_q    <= '0;
							end else begin
								gap_q       <= (sv && delta > 32'd1) ? 31'(delta - 32'd1) : '0;
								last_seq_q  <= pkt_seq_q;
								status_q    <= (pkt_proto_q == PROTO_TWO) ? STAT_PROTO2 : STAT_PROTO1;
							end
						end
						byte_count_q <= '0;
						first_err_q  <= 4'd0;
						pkt_proto_q  <= PROTO_NONE;
						pkt_seq_q    <= '0;
						slot_q       <= '0;
						bone_q       <= '0;
						st_q         <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign bone_index   = bone_index_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign quat_w       = quat_w_q;
	assign quat_x       = quat_x_q;
	assign quat_y       = quat_y_q;
	assign quat_z       = quat_z_q;
	assign status       = status_q;
	assign sequence_res = seq_res_q;
	assign dropped_gap  = gap_q;

endmodule

// ----- rtl/core/ppv_checker.sv -----
// Port-level checker for the pose packet validator, bound to the top level.
`include "assert_macros.svh"
module ppv_checker import ppv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [3:0]  bone_index,
	input logic [31:0] pos_x,
	input logic [31:0] quat_w,
	input logic [31:0] quat_x,
	input logic [3:0]  status,
	input logic [30:0] dropped_gap
);

	`PPV_ASSERT_IMPL(a_status_range, out_valid, status <= STAT_OLD)
	`PPV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(quat_w))
	`PPV_ASSERT_IMPL(a_verdict_zero, out_valid && kind, bone_index == 4'd0 && pos_x == 32'd0 && quat_x == 32'd0)
	`PPV_ASSERT_IMPL(a_bone_nogap, out_valid && !kind, dropped_gap == 31'd0)
	`PPV_ASSERT_IMPL(a_gap_ok, out_valid && dropped_gap != 31'd0, status == STAT_PROTO1 || status == STAT_PROTO2)

endmodule

bind pose_packet_validator ppv_checker u_ppv_checker (.*);
